// ----- sv/matrix_vector_transform_assert.svh -----
// Assertion macros for the matrix vector transform block.
`ifndef MATRIX_VECTOR_TRANSFORM_ASSERT_SVH
`define MATRIX_VECTOR_TRANSFORM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mvt_pkg.sv -----
// Shared types and constants for the matrix vector transform block.
`timescale 1ns / 1ps

package mvt_pkg;

    // Matrix dimension and the part of it that four components can reach.
    localparam int DIM    = 4;
    localparam int NUSE   = (DIM < 4) ? DIM : 4;
    localparam int ROW_W  = (NUSE > 1) ? $clog2(NUSE) : 1;
    localparam int WORD_W = 32;
    localparam int PROD_W = 2 * WORD_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int FRAC_W = 16;
    localparam int SLOT_W = 2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_XFORM = 1'b1;

    typedef struct packed {
        logic                     command;
        logic [1:0]               row;
        logic [1:0]               col;
        logic signed [WORD_W-1:0] load_value;
        logic signed [WORD_W-1:0] vec_x;
        logic signed [WORD_W-1:0] vec_y;
        logic signed [WORD_W-1:0] vec_z;
        logic signed [WORD_W-1:0] vec_w;
    } mvt_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] out_x;
        logic signed [WORD_W-1:0] out_y;
        logic signed [WORD_W-1:0] out_z;
        logic signed [WORD_W-1:0] out_w;
        logic                     overflow;
    } mvt_out_t;

    // Travels alongside one row through the dot-product pipeline.
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } mvt_tag_t;

    typedef logic [NUSE-1:0][WORD_W-1:0] mvt_row_t;

endpackage

// ----- sv/mvt_dot_unit.sv -----
// Pipelined dot-product unit: one matrix row against the vector, floor shift, saturation.
`timescale 1ns / 1ps

module mvt_dot_unit import mvt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mvt_tag_t          tag_in,
    input  mvt_row_t          coeff_row,
    input  mvt_row_t          vec,
    output mvt_tag_t          tag_out,
    output logic [WORD_W-1:0] value,
    output logic              sat
);

    logic signed [PROD_W-1:0] prod_reg [NUSE];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    mvt_tag_t                 tag1_reg;
    mvt_tag_t                 tag2_reg;
    logic [SUM_W-FRAC_W-1:0]  shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
        end
    end

    // One lane per matrix column, each a full-width signed product.
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUSE; c++)
        begin
            prod_reg[c] <= $signed(coeff_row[c]) * $signed(vec[c]);
        end
        sum_reg <= sum_next;
    end

    always_comb
    begin
        sum_next = '0;
        for (int c = 0; c < NUSE; c++)
        begin
            sum_next = sum_next + SUM_W'(prod_reg[c]);
        end
    end

    // Dropping the low bits of the exact sum is a floor division by 2^16.
    assign shifted = sum_reg[SUM_W-1:FRAC_W];

    always_comb
    begin
        sat   = (shifted[SUM_W-FRAC_W-1:WORD_W-1] != '0)
             && (shifted[SUM_W-FRAC_W-1:WORD_W-1] != '1);
        value = shifted[WORD_W-1:0];
        if (sat)
        begin
            value = shifted[SUM_W-FRAC_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                            : {1'b0, {(WORD_W-1){1'b1}}};
        end
    end

    assign tag_out = tag2_reg;

endmodule

// ----- sv/matrix_vector_transform.sv -----
// Top level of the 4x4 Q16.16 matrix vector transform engine.
// Usage: a command is transferred at a rising edge where start is high and busy is low.
// A load command writes one coefficient of the matrix in that same edge and produces
// no result; busy stays low, so commands may follow in every cycle.
// A transform command raises busy until done is raised. One shared dot-product unit takes one
// matrix row per cycle (four 32x32 multipliers, then a registered adder, then a floor
// shift and saturation), so the four rows enter one after another and the last row
// then leaves the two-stage pipeline. The result is shown on result for exactly one
// cycle while done is high; busy is already low in that cycle, so the next command
// may be transferred at the edge that ends it, and no command is taken before then.
// The receiver cannot stall: a result must be taken in its done cycle.
// overflow is set when any of the four components saturated.
// Reset clears the coefficient matrix to zero, drops busy and done and abandons any
// transform in flight.
`timescale 1ns / 1ps
`include "matrix_vector_transform_assert.svh"

module matrix_vector_transform import mvt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  mvt_in_t  request,
    output logic     busy,
    output logic     done,
    output mvt_out_t result
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              state_reg;
    logic              issuing_reg;
    logic [ROW_W-1:0]  iss_reg;
    logic              done_reg;
    logic              ovf_reg;
    logic [WORD_W-1:0] coeff_reg [NUSE][NUSE];
    mvt_row_t          vec_reg;
    logic [WORD_W-1:0] res_reg [4];

    logic              accept;
    logic              load_hit;
    logic [WORD_W-1:0] vec_in [4];
    mvt_row_t          coeff_row;
    mvt_tag_t          tag_in;
    mvt_tag_t          tag_out;
    logic [WORD_W-1:0] dot_value;
    logic              dot_sat;

    assign accept   = start && !busy;
    assign load_hit = (int'(request.row) < NUSE) && (int'(request.col) < NUSE);

    assign vec_in[0] = request.vec_x;
    assign vec_in[1] = request.vec_y;
    assign vec_in[2] = request.vec_z;
    assign vec_in[3] = request.vec_w;

    always_comb
    begin
        for (int c = 0; c < NUSE; c++)
        begin
            coeff_row[c] = coeff_reg[iss_reg][c];
        end
    end

    assign tag_in.valid = issuing_reg;
    assign tag_in.slot  = SLOT_W'(iss_reg);
    assign tag_in.last  = (iss_reg == ROW_W'(NUSE - 1));

    mvt_dot_unit u_dot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_in    (tag_in),
        .coeff_row (coeff_row),
        .vec       (vec_reg),
        .tag_out   (tag_out),
        .value     (dot_value),
        .sat       (dot_sat)
    );

    // Sequencer: issues rows to the dot unit and retires them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            issuing_reg <= 1'b0;
            iss_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && request.command == CMD_XFORM)
                    begin
                        state_reg   <= ST_RUN;
                        issuing_reg <= 1'b1;
                        iss_reg     <= '0;
                    end
                end
                ST_RUN:
                begin
                    if (issuing_reg)
                    begin
                        if (tag_in.last)
                        begin
                            issuing_reg <= 1'b0;
                        end
                        else
                        begin
                            iss_reg <= iss_reg + 1'b1;
                        end
                    end
                    if (tag_out.valid && tag_out.last)
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUSE; r++)
            begin
                for (int c = 0; c < NUSE; c++)
                begin
                    coeff_reg[r][c] <= '0;
                end
            end
        end
        else if (accept && request.command == CMD_LOAD && load_hit)
        begin
            coeff_reg[request.row[ROW_W-1:0]][request.col[ROW_W-1:0]] <= request.load_value;
        end
    end

    // Rows the matrix does not have stay at zero for the whole transform.
    always_ff @(posedge clk)
    begin
        if (accept && request.command == CMD_XFORM)
        begin
            for (int c = 0; c < NUSE; c++)
            begin
                vec_reg[c] <= vec_in[c];
            end
            for (int r = 0; r < 4; r++)
            begin
                res_reg[r] <= '0;
            end
            ovf_reg <= 1'b0;
        end
        else if (tag_out.valid)
        begin
            res_reg[tag_out.slot] <= dot_value;
            ovf_reg               <= ovf_reg | dot_sat;
        end
    end

    assign busy            = (state_reg == ST_RUN);
    assign done            = done_reg;
    assign result.out_x    = res_reg[0];
    assign result.out_y    = res_reg[1];
    assign result.out_z    = res_reg[2];
    assign result.out_w    = res_reg[3];
    assign result.overflow = ovf_reg;

    `MVT_ASSERT_NEXT(a_done_single, done, !done, "done held for more than one cycle")
    `MVT_ASSERT_NEXT(a_xform_busy, accept && request.command == CMD_XFORM, busy && !done,
        "transform transfer did not raise busy")
    `MVT_ASSERT_SAME(a_busy_fall_done, $fell(busy), done, "busy dropped without a result")
    `MVT_ASSERT_SAME(a_retire_busy, tag_out.valid, busy, "row retired while idle")

endmodule

// ----- dv/matrix_vector_transform_tb.sv -----
// Self-checking testbench for the 4x4 Q16.16 matrix vector transform engine.
`timescale 1ns / 1ps

module matrix_vector_transform_tb;
    import mvt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 600;
    localparam int CALM_TAIL    = 120;
    localparam int DRAIN_CYCLES = 10;
    localparam int REPORT_MAX   = 10;

    // Keeps its own copy of the coefficients and the transforms still in flight.
    class transform_scoreboard;
        logic signed [WORD_W-1:0] coeff [4][4];
        mvt_out_t                 expected_vectors [$];
        int                       errors;
        int                       mismatches;
        int                       loads;
        int                       transforms;
        int                       saturations;

        function new();
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    coeff[r][c] = '0;
                end
            end
            errors      = 0;
            mismatches  = 0;
            loads       = 0;
            transforms  = 0;
            saturations = 0;
        endfunction

        function int pending();
            return expected_vectors.size();
        endfunction

        // Each row: exact sum of full-width products, floor shift, then saturate.
        function mvt_out_t transform_vector(mvt_in_t cmd);
            logic signed [WORD_W-1:0] vec [4];
            logic signed [WORD_W-1:0] row_out [4];
            logic signed [SUM_W-1:0]  acc;
            logic signed [PROD_W-1:0] prod;
            mvt_out_t                 res;
            logic                     sat;
            vec[0] = cmd.vec_x;
            vec[1] = cmd.vec_y;
            vec[2] = cmd.vec_z;
            vec[3] = cmd.vec_w;
            sat = 1'b0;
            for (int r = 0; r < 4; r++)
            begin
                row_out[r] = '0;
                if (r < NUSE)
                begin
                    acc = '0;
                    for (int c = 0; c < NUSE; c++)
                    begin
                        prod = coeff[r][c] * vec[c];
                        acc  = acc + prod;
                    end
                    acc = acc >>> FRAC_W;
                    // The value fits in 32 bits only if the top bits all copy the sign.
                    if (acc[SUM_W-1:WORD_W-1] != '0 && acc[SUM_W-1:WORD_W-1] != '1)
                    begin
                        sat        = 1'b1;
                        row_out[r] = acc[SUM_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
                    end
                    else
                    begin
                        row_out[r] = acc[WORD_W-1:0];
                    end
                end
            end
            res.out_x    = row_out[0];
            res.out_y    = row_out[1];
            res.out_z    = row_out[2];
            res.out_w    = row_out[3];
            res.overflow = sat;
            return res;
        endfunction

        function void note_command(mvt_in_t cmd);
            mvt_out_t res;
            if (cmd.command == CMD_LOAD)
            begin
                loads++;
                if (cmd.row < DIM && cmd.col < DIM)
                begin
                    coeff[cmd.row][cmd.col] = cmd.load_value;
                end
            end
            else
            begin
                transforms++;
                res = transform_vector(cmd);
                if (res.overflow)
                begin
                    saturations++;
                end
                expected_vectors.push_back(res);
            end
        endfunction

        function void check_result(mvt_out_t got);
            mvt_out_t want;
            if (expected_vectors.size() == 0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("ERROR: result with no transform outstanding: %h %h %h %h ovf=%b",
                             got.out_x, got.out_y, got.out_z, got.out_w, got.overflow);
                end
                return;
            end
            want = expected_vectors.pop_front();
            if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
                got.out_z !== want.out_z || got.out_w !== want.out_w ||
                got.overflow !== want.overflow)
            begin
                errors++;
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("ERROR: transform result mismatch");
                    $display("  expected x=%h y=%h z=%h w=%h ovf=%b",
                             want.out_x, want.out_y, want.out_z, want.out_w, want.overflow);
                    $display("  actual   x=%h y=%h z=%h w=%h ovf=%b",
                             got.out_x, got.out_y, got.out_z, got.out_w, got.overflow);
                end
            end
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    mvt_in_t  request;
    logic     busy;
    logic     done;
    mvt_out_t result;

    transform_scoreboard sb;
    int                  cycle_count = 0;

    matrix_vector_transform dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .request(request),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    // Values before the edge are seen here, so the check order is race free.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                sb.check_result(result);
            end
            if (start && !busy)
            begin
                sb.note_command(request);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ERROR: timed out with %0d transforms outstanding", sb.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Modest Q16.16 values, with zero, tiny values, the extremes and full-range words mixed in.
    function automatic logic [WORD_W-1:0] pick_q16();
        unique case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return $urandom_range(0, 7) - 3;
            4, 5:    return $urandom();
            default: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
        endcase
    endfunction

    // Fields that the command ignores are filled with noise as well.
    function automatic mvt_in_t random_command();
        mvt_in_t cmd;
        cmd.command    = ($urandom_range(0, 9) < 4) ? CMD_LOAD : CMD_XFORM;
        cmd.row        = 2'($urandom_range(0, 3));
        cmd.col        = 2'($urandom_range(0, 3));
        cmd.load_value = pick_q16();
        cmd.vec_x      = pick_q16();
        cmd.vec_y      = pick_q16();
        cmd.vec_z      = pick_q16();
        cmd.vec_w      = pick_q16();
        return cmd;
    endfunction

    // Holds start high until the command is transferred.
    task automatic issue_command(input mvt_in_t cmd, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= cmd;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic load_coeff(input int r, input int c, input logic [WORD_W-1:0] value);
        mvt_in_t cmd;
        cmd            = random_command();
        cmd.command    = CMD_LOAD;
        cmd.row        = 2'(r);
        cmd.col        = 2'(c);
        cmd.load_value = value;
        issue_command(cmd, 0);
    endtask

    task automatic transform(input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y,
                             input logic [WORD_W-1:0] z, input logic [WORD_W-1:0] w);
        mvt_in_t cmd;
        cmd         = random_command();
        cmd.command = CMD_XFORM;
        cmd.vec_x   = x;
        cmd.vec_y   = y;
        cmd.vec_z   = z;
        cmd.vec_w   = w;
        issue_command(cmd, 0);
    endtask

    initial
    begin
        mvt_in_t cmd;
        int      gap;
        sb          = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The cleared matrix maps everything to zero.
        transform(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0001);
        // Identity: components pass through unchanged.
        for (int i = 0; i < 4; i++)
        begin
            load_coeff(i, i, 32'h0001_0000);
        end
        transform(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0001);
        // Coefficient extremes so that rows saturate both ways.
        load_coeff(0, 1, 32'h7fff_ffff);
        load_coeff(1, 0, 32'h8000_0000);
        load_coeff(2, 3, 32'hffff_ffff);
        load_coeff(3, 3, 32'h8000_0000);
        transform(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        transform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        // Small negative sums check that the shift rounds toward minus infinity.
        transform(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001);
        load_coeff(3, 0, 32'h0001_8000);
        load_coeff(2, 2, 32'hffff_8000);
        transform(32'h0000_0003, 32'hffff_fffd, 32'h0000_0001, 32'hffff_ffff);
        transform('0, '0, '0, '0);
        load_coeff(0, 0, 32'h8000_0000);
        load_coeff(3, 3, 32'h7fff_ffff);
        transform(32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 32'h7fff_ffff);
        transform(32'h1234_5678, 32'hedcb_a987, 32'h0000_ffff, 32'hffff_0000);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            cmd = random_command();
            gap = 0;
            // The final stretch runs with start held high throughout.
            if (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 19);
            end
            issue_command(cmd, gap);
        end
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d coefficient loads and %0d transforms, %0d of them saturating.",
                 sb.loads, sb.transforms, sb.saturations);
        $display("Result mismatches or unexpected results: %0d", sb.mismatches);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/mvt_pkg.sv
sv/mvt_dot_unit.sv
sv/matrix_vector_transform.sv
dv/matrix_vector_transform_tb.sv
